>>> hdl/rsc_pkg.sv
// shared types, register codes and helper functions for the rabbit stream cipher
package rsc_pkg;

    localparam int unsigned CFG_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IV_VALUE  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IV_ENABLE = 4'd3;

    typedef struct packed {
        logic        restart;
        logic [63:0] data_high;
        logic [63:0] data_low;
    } rsc_in_t;

    typedef struct packed {
        logic [63:0] out_high;
        logic [63:0] out_low;
    } rsc_out_t;

    function automatic logic [31:0] ctr_const(input logic [2:0] idx);
        logic [31:0] k;
        unique case (idx)
            3'd0, 3'd3, 3'd6: k = 32'h4D34D34D;
            3'd1, 3'd4, 3'd7: k = 32'hD34D34D3;
            default:          k = 32'h34D34D34;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] rot8(input logic [31:0] v);
        return {v[23:0], v[31:24]};
    endfunction

    function automatic logic [31:0] rot16(input logic [31:0] v);
        return {v[15:0], v[31:16]};
    endfunction

endpackage

>>> hdl/rabbit_stream_cipher.sv
// rabbit stream cipher core: one 128-bit word per item, one shared squarer
// without restart an input word runs a single final iteration, then the output state raises m_valid
// restart adds key load, key setup and counter mix, plus iv setup if the iv is enabled
// each iteration runs through the single 32x32 squarer fed one word a cycle
// one word in flight at a time; s_ready low until the result is loaded
// aresetn (synchronous) clears state words, counters, carry, config registers and handshakes
module rabbit_stream_cipher (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rsc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [63:0]                     cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  rsc_pkg::rsc_in_t                s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output rsc_pkg::rsc_out_t               m_data
);
    import rsc_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_ITER = 3'd2;
    localparam logic [2:0] ST_MIX  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    localparam logic [1:0] SEG_KEY   = 2'd0;
    localparam logic [1:0] SEG_IV    = 2'd1;
    localparam logic [1:0] SEG_FINAL = 2'd2;

    localparam logic [3:0] STEP_LAST = 4'd11;

    logic [2:0]  state_reg, state_next;
    logic [1:0]  seg_reg, seg_next;
    logic [3:0]  step_reg, step_next;
    logic [2:0]  iters_reg, iters_next;

    logic [63:0] key_low_reg, key_low_next;
    logic [63:0] key_high_reg, key_high_next;
    logic [63:0] iv_value_reg, iv_value_next;
    logic        iv_enable_reg, iv_enable_next;

    logic [31:0] x_reg [8];
    logic [31:0] x_next [8];
    logic [31:0] c_reg [8];
    logic [31:0] c_next [8];
    logic [31:0] g_reg [8];
    logic [31:0] g_next [8];
    logic        carry_reg, carry_next;
    logic [31:0] u_reg, u_next;
    logic [63:0] sq_reg, sq_next;

    rsc_in_t     data_reg, data_next;
    logic        m_valid_reg, m_valid_next;
    rsc_out_t    m_data_reg, m_data_next;

    logic [15:0] subkey [8];
    logic [31:0] key_x [8];
    logic [31:0] key_c [8];
    logic [31:0] iv_word [4];
    logic [31:0] ns [8];
    logic [32:0] csum;
    logic [63:0] ks_low, ks_high;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // key expansion into state words and counters
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            subkey[j]     = key_low_reg[16*j +: 16];
            subkey[j + 4] = key_high_reg[16*j +: 16];
        end
        for (int j = 0; j < 8; j++) begin
            if ((j % 2) == 0) begin
                key_x[j] = {subkey[3'(j + 1)], subkey[3'(j)]};
                key_c[j] = {subkey[3'(j + 4)], subkey[3'(j + 5)]};
            end else begin
                key_x[j] = {subkey[3'(j + 5)], subkey[3'(j + 4)]};
                key_c[j] = {subkey[3'(j)], subkey[3'(j + 1)]};
            end
        end
    end

    assign iv_word[0] = iv_value_reg[31:0];
    assign iv_word[1] = {iv_value_reg[63:48], iv_value_reg[31:16]};
    assign iv_word[2] = iv_value_reg[63:32];
    assign iv_word[3] = {iv_value_reg[47:32], iv_value_reg[15:0]};

    // next-state function from the g values
    assign ns[0] = g_reg[0] + rot16(g_reg[7]) + rot16(g_reg[6]);
    assign ns[1] = g_reg[1] + rot8(g_reg[0])  + g_reg[7];
    assign ns[2] = g_reg[2] + rot16(g_reg[1]) + rot16(g_reg[0]);
    assign ns[3] = g_reg[3] + rot8(g_reg[2])  + g_reg[1];
    assign ns[4] = g_reg[4] + rot16(g_reg[3]) + rot16(g_reg[2]);
    assign ns[5] = g_reg[5] + rot8(g_reg[4])  + g_reg[3];
    assign ns[6] = g_reg[6] + rot16(g_reg[5]) + rot16(g_reg[4]);
    assign ns[7] = g_reg[7] + rot8(g_reg[6])  + g_reg[5];

    assign ks_low = {x_reg[2][31:16] ^ x_reg[5][15:0], x_reg[2][15:0] ^ x_reg[7][31:16],
                     x_reg[0][31:16] ^ x_reg[3][15:0], x_reg[0][15:0] ^ x_reg[5][31:16]};
    assign ks_high = {x_reg[6][31:16] ^ x_reg[1][15:0], x_reg[6][15:0] ^ x_reg[3][31:16],
                      x_reg[4][31:16] ^ x_reg[7][15:0], x_reg[4][15:0] ^ x_reg[1][31:16]};

    // counter word at the head of the rotating counter array
    assign csum = {1'b0, c_reg[0]} + {1'b0, ctr_const(step_reg[2:0])} + 33'(carry_reg);

    always_comb begin
        state_next     = state_reg;
        seg_next       = seg_reg;
        step_next      = step_reg;
        iters_next     = iters_reg;
        key_low_next   = key_low_reg;
        key_high_next  = key_high_reg;
        iv_value_next  = iv_value_reg;
        iv_enable_next = iv_enable_reg;
        x_next         = x_reg;
        c_next         = c_reg;
        g_next         = g_reg;
        carry_next     = carry_reg;
        u_next         = u_reg;
        sq_next        = sq_reg;
        data_next      = data_reg;
        m_data_next    = m_data_reg;
        m_valid_next   = m_valid_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_valid) begin
            unique case (cfg_index)
                REG_KEY_LOW:   key_low_next   = cfg_data;
                REG_KEY_HIGH:  key_high_next  = cfg_data;
                REG_IV_VALUE:  iv_value_next  = cfg_data;
                REG_IV_ENABLE: iv_enable_next = cfg_data[0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    data_next = s_data;
                    step_next = '0;
                    if (s_data.restart) begin
                        state_next = ST_LOAD;
                    end else begin
                        state_next = ST_ITER;
                        seg_next   = SEG_FINAL;
                        iters_next = 3'd1;
                    end
                end
            end
            ST_LOAD: begin
                x_next     = key_x;
                c_next     = key_c;
                carry_next = 1'b0;
                state_next = ST_ITER;
                seg_next   = SEG_KEY;
                iters_next = 3'd4;
                step_next  = '0;
            end
            ST_ITER: begin
                // counter update, one word a cycle, array rotates back into order
                if (step_reg < 4'd8) begin
                    for (int k = 0; k < 7; k++) begin
                        c_next[k] = c_reg[k + 1];
                    end
                    c_next[7]  = csum[31:0];
                    carry_next = csum[32];
                end
                // counter word written in the step before sits at the tail
                if (step_reg >= 4'd1 && step_reg <= 4'd8) begin
                    u_next = x_reg[0] + c_reg[7];
                    for (int k = 0; k < 7; k++) begin
                        x_next[k] = x_reg[k + 1];
                    end
                    x_next[7] = x_reg[0];
                end
                if (step_reg >= 4'd2 && step_reg <= 4'd9) begin
                    sq_next = 64'(u_reg) * 64'(u_reg);
                end
                if (step_reg >= 4'd3 && step_reg <= 4'd10) begin
                    for (int k = 0; k < 7; k++) begin
                        g_next[k] = g_reg[k + 1];
                    end
                    g_next[7] = sq_reg[31:0] ^ sq_reg[63:32];
                end
                if (step_reg == STEP_LAST) begin
                    x_next     = ns;
                    step_next  = '0;
                    iters_next = iters_reg - 3'd1;
                    if (iters_reg == 3'd1) begin
                        unique case (seg_reg)
                            SEG_KEY: state_next = ST_MIX;
                            SEG_IV: begin
                                seg_next   = SEG_FINAL;
                                iters_next = 3'd1;
                            end
                            default: state_next = ST_OUT;
                        endcase
                    end
                end else begin
                    step_next = step_reg + 4'd1;
                end
            end
            ST_MIX: begin
                for (int j = 0; j < 8; j++) begin
                    c_next[j] = c_reg[j] ^ x_reg[3'(j + 4)]
                              ^ (iv_enable_reg ? iv_word[2'(j)] : 32'd0);
                end
                state_next = ST_ITER;
                step_next  = '0;
                if (iv_enable_reg) begin
                    seg_next   = SEG_IV;
                    iters_next = 3'd4;
                end else begin
                    seg_next   = SEG_FINAL;
                    iters_next = 3'd1;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next.out_low  = data_reg.data_low ^ ks_low;
                    m_data_next.out_high = data_reg.data_high ^ ks_high;
                    m_valid_next         = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            seg_reg       <= SEG_KEY;
            step_reg      <= '0;
            iters_reg     <= '0;
            key_low_reg   <= '0;
            key_high_reg  <= '0;
            iv_value_reg  <= '0;
            iv_enable_reg <= 1'b0;
            for (int j = 0; j < 8; j++) begin
                x_reg[j] <= '0;
                c_reg[j] <= '0;
            end
            carry_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            seg_reg       <= seg_next;
            step_reg      <= step_next;
            iters_reg     <= iters_next;
            key_low_reg   <= key_low_next;
            key_high_reg  <= key_high_next;
            iv_value_reg  <= iv_value_next;
            iv_enable_reg <= iv_enable_next;
            x_reg         <= x_next;
            c_reg         <= c_next;
            carry_reg     <= carry_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        g_reg      <= g_next;
        u_reg      <= u_next;
        sq_reg     <= sq_next;
        data_reg   <= data_next;
        m_data_reg <= m_data_next;
    end

endmodule

>>> hdl/rsc_checker.sv
// port-level checks for the rabbit stream cipher, bound to the top level
module rsc_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input rsc_pkg::rsc_out_t               m_data
);

    // one word in flight: the input side closes right after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("s_ready still high after an input word was taken");

    // a result never shows up the cycle after an input word
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("result appeared one cycle after input accept");

    // a new result is only loaded while the core is busy
    a_result_from_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result loaded while the core was idle");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result word changed or dropped");

endmodule

bind rabbit_stream_cipher rsc_checker u_rsc_checker (.*);
